[rtl/core/imhtq_pkg.sv]
// Package for the indexed min-heap timeout queue.
// Holds sizes, operation and status codes, and the transfer payload structs.
// No dependencies.
package imhtq_pkg;

  localparam int unsigned Capacity  = 64;
  localparam int unsigned SlotBits  = $clog2(Capacity);
  localparam int unsigned CountBits = SlotBits + 1;
  localparam int unsigned IdBits    = 6;
  localparam int unsigned TimeBits  = 32;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_UPDATE = 2'd1,
    OP_POP    = 2'd2,
    OP_REMOVE = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_ABSENT  = 3'd3,
    ST_PRESENT = 3'd4
  } status_e;

  typedef struct packed {
    logic [1:0]          mode;
    logic [IdBits-1:0]   item_id;
    logic [TimeBits-1:0] item_time;
  } req_t;

  typedef struct packed {
    logic [2:0]          status;
    logic [6:0]          entry_count;
    logic                head_valid;
    logic [IdBits-1:0]   head_id;
    logic [TimeBits-1:0] head_time;
  } rsp_t;

  typedef struct packed {
    logic [IdBits-1:0]   id;
    logic [TimeBits-1:0] tm;
  } entry_t;

  typedef struct packed {
    logic                present;
    logic [SlotBits-1:0] slot;
  } pos_t;

endpackage

[rtl/core/indexed_min_heap_timeout_queue_top.sv]
// Top level of the indexed min-heap timeout queue.
// Depends on imhtq_pkg and imhtq_heap_ram; holds the sequencer, position map and present bits.
//
//   channel  | valid / stall             | payload
//   request  | req_valid_i / req_stall_o | imhtq_pkg::req_t
//   response | rsp_valid_o / rsp_stall_i | imhtq_pkg::rsp_t
//
// A sift level up is a parent read and a compare; a level down is two child reads and a compare;
// the single read port of the slot memory sets that order. A rejected operation goes from decode
// straight to the head read and the response. A request is taken only in idle, so one item has
// reached its response before the next one starts.
// After reset the queue is empty and every id absent; the memories are not cleared.
// The response register holds while rsp_stall_i is high; the next item may start meanwhile.
module indexed_min_heap_timeout_queue_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  output logic               req_stall_o,
  input  imhtq_pkg::req_t    req_i,
  output logic               rsp_valid_o,
  input  logic               rsp_stall_i,
  output imhtq_pkg::rsp_t    rsp_o
);

  localparam int unsigned SB      = imhtq_pkg::SlotBits;
  localparam int unsigned CB      = imhtq_pkg::CountBits;
  localparam int unsigned IB      = imhtq_pkg::IdBits;
  localparam int unsigned IdSpace = 2 ** imhtq_pkg::IdBits;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DEC    = 4'd1;
  localparam logic [3:0] S_RDAT   = 4'd2;
  localparam logic [3:0] S_RDLAST = 4'd3;
  localparam logic [3:0] S_FIX    = 4'd4;
  localparam logic [3:0] S_UPRD   = 4'd5;
  localparam logic [3:0] S_UPCMP  = 4'd6;
  localparam logic [3:0] S_DNL    = 4'd7;
  localparam logic [3:0] S_DNR    = 4'd8;
  localparam logic [3:0] S_DNCMP  = 4'd9;
  localparam logic [3:0] S_WB     = 4'd10;
  localparam logic [3:0] S_HREQ   = 4'd11;
  localparam logic [3:0] S_HEAD   = 4'd12;

  logic [3:0]            state_q;
  imhtq_pkg::req_t       req_q;
  logic [CB-1:0]         count_q;
  logic [SB-1:0]         at_q;
  imhtq_pkg::entry_t     cur_q;     // entry being sifted
  imhtq_pkg::entry_t     rd_q;      // saved read of slot at
  imhtq_pkg::entry_t     best_q;
  logic [SB-1:0]         best_a_q;
  logic                  best_v_q;
  logic                  up_first_q;
  logic [2:0]            status_q;
  logic [IdSpace-1:0]    present_q;
  imhtq_pkg::rsp_t       rsp_q;
  logic                  rsp_v_q;
  logic                  rsp_v_d;

  logic [SB-1:0]         pmap_mem_q [IdSpace];
  logic [SB-1:0]         pmap_rdata_q;
  logic                  pmap_we;
  logic [IB-1:0]         pmap_waddr, pmap_raddr;
  logic [SB-1:0]         pmap_wdata;

  logic                  heap_we;
  logic [SB-1:0]         heap_waddr, heap_raddr;
  imhtq_pkg::entry_t     heap_wdata, heap_rdata;

  imhtq_heap_ram u_ram (
    .clk_i  (clk_i),
    .we_i   (heap_we),
    .waddr_i(heap_waddr),
    .wdata_i(heap_wdata),
    .raddr_i(heap_raddr),
    .rdata_o(heap_rdata)
  );

  logic [SB-1:0]     last_slot, parent, lchild, rchild, dn_sel_a;
  logic [CB-1:0]     lch_w;
  logic [CB:0]       rch_w;
  logic              id_present, up_swap, left_win, right_win, dn_swap, rsp_load;
  imhtq_pkg::entry_t dn_sel;

  assign last_slot  = SB'(count_q - CB'(1));
  assign parent     = SB'((at_q - SB'(1)) >> 1);
  assign lch_w      = {at_q, 1'b1};
  assign rch_w      = {1'b0, at_q, 1'b0} + (CB+1)'(2);
  assign lchild     = lch_w[SB-1:0];
  assign rchild     = rch_w[SB-1:0];
  assign id_present = present_q[req_q.item_id];
  assign up_swap    = cur_q.tm < heap_rdata.tm;
  assign left_win   = (lch_w < count_q) && (heap_rdata.tm < cur_q.tm);
  assign right_win  = (rch_w < {1'b0, count_q}) && (heap_rdata.tm < best_q.tm);
  assign dn_swap    = right_win || best_v_q;
  assign dn_sel     = right_win ? heap_rdata : best_q;
  assign dn_sel_a   = right_win ? rchild : best_a_q;
  assign rsp_load   = (state_q == S_HEAD) && !(rsp_v_q && rsp_stall_i);
  assign rsp_v_d    = rsp_load || (rsp_v_q && rsp_stall_i);
  assign pmap_raddr = (state_q == S_IDLE) ? req_i.item_id : req_q.item_id;

  assign req_stall_o = (state_q != S_IDLE);
  assign rsp_valid_o = rsp_v_q;
  assign rsp_o       = rsp_q;

  always_comb begin
    heap_raddr = at_q;
    heap_we    = 1'b0;
    heap_waddr = at_q;
    heap_wdata = cur_q;
    pmap_we    = 1'b0;
    pmap_waddr = cur_q.id;
    pmap_wdata = at_q;
    unique case (state_q)
      S_RDLAST: heap_raddr = last_slot;
      S_UPRD:   heap_raddr = parent;
      S_UPCMP: begin
        if (up_swap) begin
          heap_we    = 1'b1;
          heap_wdata = heap_rdata;
          pmap_we    = 1'b1;
          pmap_waddr = heap_rdata.id;
        end
      end
      S_DNL:    heap_raddr = lchild;
      S_DNR:    heap_raddr = rchild;
      S_DNCMP: begin
        if (dn_swap) begin
          heap_we    = 1'b1;
          heap_wdata = dn_sel;
          pmap_we    = 1'b1;
          pmap_waddr = dn_sel.id;
        end
      end
      S_WB: begin
        heap_we = 1'b1;
        pmap_we = 1'b1;
      end
      S_HREQ, S_HEAD: heap_raddr = '0;
      default: heap_raddr = at_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pmap_we) begin
      pmap_mem_q[pmap_waddr] <= pmap_wdata;
    end
    pmap_rdata_q <= pmap_mem_q[pmap_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      req_q      <= '0;
      count_q    <= '0;
      at_q       <= '0;
      cur_q      <= '0;
      rd_q       <= '0;
      best_q     <= '0;
      best_a_q   <= '0;
      best_v_q   <= 1'b0;
      up_first_q <= 1'b0;
      status_q   <= imhtq_pkg::ST_OK;
      present_q  <= '0;
      rsp_q      <= '0;
      rsp_v_q    <= 1'b0;
    end else begin
      rsp_v_q <= rsp_v_d;
      unique case (state_q)
        S_IDLE: begin
          if (req_valid_i) begin
            req_q    <= req_i;
            status_q <= imhtq_pkg::ST_OK;
            state_q  <= S_DEC;
          end
        end
        S_DEC: begin
          case (req_q.mode)
            imhtq_pkg::OP_INSERT: begin
              if (id_present) begin
                status_q <= imhtq_pkg::ST_PRESENT; state_q <= S_HREQ;
              end else if (count_q == CB'(imhtq_pkg::Capacity)) begin
                status_q <= imhtq_pkg::ST_FULL; state_q <= S_HREQ;
              end else begin
                at_q       <= SB'(count_q);
                cur_q      <= '{id: req_q.item_id, tm: req_q.item_time};
                present_q[req_q.item_id] <= 1'b1;
                count_q    <= count_q + CB'(1);
                up_first_q <= 1'b0;
                state_q    <= S_UPRD;
              end
            end
            imhtq_pkg::OP_UPDATE: begin
              if (!id_present) begin
                status_q <= imhtq_pkg::ST_ABSENT; state_q <= S_HREQ;
              end else begin
                at_q    <= pmap_rdata_q;
                state_q <= S_RDAT;
              end
            end
            imhtq_pkg::OP_POP: begin
              if (count_q == '0) begin
                status_q <= imhtq_pkg::ST_EMPTY; state_q <= S_HREQ;
              end else begin
                at_q    <= '0;
                state_q <= S_RDAT;
              end
            end
            default: begin
              if (count_q == '0) begin
                status_q <= imhtq_pkg::ST_EMPTY; state_q <= S_HREQ;
              end else if (!id_present) begin
                status_q <= imhtq_pkg::ST_ABSENT; state_q <= S_HREQ;
              end else begin
                at_q    <= pmap_rdata_q;
                state_q <= S_RDAT;
              end
            end
          endcase
        end
        S_RDAT: state_q <= S_RDLAST;
        S_RDLAST: begin
          rd_q    <= heap_rdata;
          state_q <= S_FIX;
        end
        S_FIX: begin
          if (req_q.mode == imhtq_pkg::OP_UPDATE) begin
            cur_q      <= '{id: req_q.item_id, tm: req_q.item_time};
            up_first_q <= 1'b0;
            if (req_q.item_time < rd_q.tm) state_q <= S_UPRD;
            else                           state_q <= S_DNL;
          end else begin
            present_q[rd_q.id] <= 1'b0;
            count_q    <= count_q - CB'(1);
            cur_q      <= heap_rdata;
            up_first_q <= 1'b1;
            if (at_q == last_slot) state_q <= S_HREQ;
            else if (at_q != '0)   state_q <= S_UPRD;
            else                   state_q <= S_DNL;
          end
        end
        S_UPRD: begin
          if (at_q == '0) state_q <= S_WB;
          else            state_q <= S_UPCMP;
        end
        S_UPCMP: begin
          if (up_swap) begin
            at_q       <= parent;
            up_first_q <= 1'b0;
            state_q    <= S_UPRD;
          end else if (up_first_q) begin
            up_first_q <= 1'b0;
            state_q    <= S_DNL;
          end else begin
            state_q <= S_WB;
          end
        end
        S_DNL: begin
          if (lch_w >= count_q) state_q <= S_WB;
          else                  state_q <= S_DNR;
        end
        S_DNR: begin
          best_q   <= left_win ? heap_rdata : cur_q;
          best_a_q <= lchild;
          best_v_q <= left_win;
          state_q  <= S_DNCMP;
        end
        S_DNCMP: begin
          if (dn_swap) begin
            at_q    <= dn_sel_a;
            state_q <= S_DNL;
          end else begin
            state_q <= S_WB;
          end
        end
        S_WB:   state_q <= S_HREQ;
        S_HREQ: state_q <= S_HEAD;
        S_HEAD: begin
          if (rsp_load) begin
            rsp_q.status      <= status_q;
            rsp_q.entry_count <= 7'(count_q);
            rsp_q.head_valid  <= (count_q != '0);
            rsp_q.head_id     <= (count_q != '0) ? heap_rdata.id : '0;
            rsp_q.head_time   <= (count_q != '0) ? heap_rdata.tm : '0;
            state_q           <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/core/imhtq_heap_ram.sv]
// Heap slot memory: one entry (id, time) per slot.
// Depends on imhtq_pkg. One write port and one registered read port.
module imhtq_heap_ram (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [imhtq_pkg::SlotBits-1:0] waddr_i,
  input  imhtq_pkg::entry_t              wdata_i,
  input  logic [imhtq_pkg::SlotBits-1:0] raddr_i,
  output imhtq_pkg::entry_t              rdata_o
);

  imhtq_pkg::entry_t mem_q [imhtq_pkg::Capacity];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
